// ----- rtl/bmrt_pkg.sv -----
// Package: shared constants, request codes and controller/datapath interface types.
`default_nettype none
package bmrt_pkg;
   localparam int MAX_READERS_DEF = 8;
   localparam int MSG_DEPTH_DEF   = 64;
   localparam logic [6:0] CAP_RESET = 7'd64;

   localparam logic [2:0] REQ_WRITE = 3'd0;
   localparam logic [2:0] REQ_READ  = 3'd1;
   localparam logic [2:0] REQ_POLL  = 3'd2;
   localparam logic [2:0] REQ_CLOSE = 3'd3;
   localparam logic [2:0] REQ_RESET = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NONEW = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0] req;
      logic [7:0] id;
      logic [7:0] data;
      logic       bvalid;
      logic       last;
      logic [6:0] max_len;
   } item_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture input beat
      logic search;    // step search pointer
      logic exec;      // apply the item's state update
      logic stream;    // advance read pointer
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic search_done;
      logic stream_last;
      logic has_stream;
      logic has_result;
   } stat_type;
endpackage
`default_nettype wire

// ----- rtl/broadcast_mailbox_with_reader_table.sv -----
// Top level: broadcast mailbox with reader table.
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata, tuser, tlast
// rsp     | out | rsp_tvalid/tready    | tdata, tuser, tlast
// csr     | in  | csr_valid/ready      | message_capacity
// An item passes through the accepting cycle, a table search of up to MAX_READERS
// entries (one entry per cycle, then a final check to confirm a miss), execute,
// then the result beats (none for a silent write item or a spare code).
// Reset clears counts and generation; stores need no clearing.
// A stalled rsp beat holds; no new req is taken until all results are gone.
`default_nettype none
module broadcast_mailbox_with_reader_table
   import bmrt_pkg::*;
#(
   parameter int MAX_READERS = MAX_READERS_DEF,
   parameter int MSG_DEPTH   = MSG_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // reader_id[7:0], data_byte[15:8], max_len[22:16]
   input  wire logic [3:0]  req_tuser,  // req_type[2:0], byte_valid[3]
   input  wire logic        req_tlast,  // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // status[1:0], data_byte_out[9:2], length[16:10]
   output logic             rsp_tuser,  // byte_present
   output logic             rsp_tlast,  // last_result
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data    // message_capacity[6:0]
);
   item_type item;
   cmd_type  cmd;
   stat_type stat;
   logic [1:0] st;
   logic [7:0] db;
   logic pres, lst;
   logic [6:0] len;

   assign item = '{req: req_tuser[2:0], id: req_tdata[7:0], data: req_tdata[15:8],
                   bvalid: req_tuser[3], last: req_tlast, max_len: req_tdata[22:16]};
   assign csr_ready = 1'b1;

   bmrt_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .out_ready(rsp_tready), .out_valid(rsp_tvalid), .stat, .cmd
   );

   bmrt_datapath #(.MAX_READERS(MAX_READERS), .MSG_DEPTH(MSG_DEPTH)) u_dp (
      .clock, .reset, .item, .cfg_we(csr_valid), .cfg_data(csr_data[6:0]),
      .cmd, .out_ready(rsp_tready), .stat, .o_status(st), .o_data(db),
      .o_present(pres), .o_last(lst), .o_length(len)
   );

   assign rsp_tdata = {7'd0, len, db, st};
   assign rsp_tuser = pres;
   assign rsp_tlast = lst;

   logic unused_top;
   assign unused_top = ^{req_tdata[23], csr_data[7]};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept while result pending");
   a_ctrl_one: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.exec, cmd.stream})) else $error("command overlap");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("stalled beat moved");
endmodule
`default_nettype wire

// ----- rtl/bmrt_ctrl.sv -----
// Controller: sequences capture, table search, execute and result streaming.
`default_nettype none
module bmrt_ctrl
   import bmrt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire logic     out_ready,
   output logic          out_valid,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SEARCH = 5'b00010,
      S_EXEC   = 5'b00100,
      S_RESP   = 5'b01000,
      S_STREAM = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      in_ready   = 1'b0;
      out_valid  = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.search_done) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.has_stream)      state_in = S_STREAM;
            else if (stat.has_result) state_in = S_RESP;
            else                      state_in = S_IDLE;
         end
         S_RESP: begin
            out_valid = 1'b1;
            if (out_ready) state_in = S_IDLE;
         end
         S_STREAM: begin
            out_valid = 1'b1;
            if (out_ready) begin
               cmd.stream = 1'b1;
               if (stat.stream_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- rtl/bmrt_datapath.sv -----
// Datapath: message store, reader table, generation and result formatting.
`default_nettype none
module bmrt_datapath
   import bmrt_pkg::*;
#(
   parameter int MAX_READERS = MAX_READERS_DEF,
   parameter int MSG_DEPTH   = MSG_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire item_type item,
   input  wire logic     cfg_we,
   input  wire logic [6:0] cfg_data,
   input  wire cmd_type  cmd,
   input  wire logic     out_ready,
   output stat_type      stat,
   output logic [1:0]    o_status,
   output logic [7:0]    o_data,
   output logic          o_present,
   output logic          o_last,
   output logic [6:0]    o_length
);
   localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
   localparam int CW = $clog2(MAX_READERS + 1);
   localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
   localparam logic [CW-1:0] MAXR = CW'(MAX_READERS);
   localparam logic [6:0]    DEP  = 7'(MSG_DEPTH);

   logic [7:0]  store [MSG_DEPTH];
   logic [7:0]  ids_ff [MAX_READERS];
   logic [31:0] seen_ff [MAX_READERS];
   item_type    it_ff;
   logic [6:0]  cap_ff, len_ff, wpos_ff;
   logic [31:0] gen_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] sp_ff;
   logic        found_ff;
   logic [RW-1:0] fidx_ff;
   logic [1:0]  st_ff;
   logic [6:0]  rlen_ff, rpos_ff, olen_ff;
   logic        pres_ff;
   logic [7:0]  rd_ff;

   logic [6:0]  cap, nrd, wr_pos, wr_len, olen_exec, rpos_nx;
   logic [1:0]  st_exec;
   logic [31:0] gen_next;
   logic        is_new, full, hit, sdone, wr_take, strm_now, res_now;
   logic [RW-1:0] last_idx, sidx, newidx;
   logic [AW-1:0] rd_addr;

   assign cap      = (cap_ff > DEP) ? DEP : cap_ff;
   assign gen_next = (gen_ff == 32'hFFFF_FFFF) ? 32'd1 : gen_ff + 32'd1;
   assign sidx     = sp_ff[RW-1:0];
   assign hit      = (sp_ff < cnt_ff) && (ids_ff[sidx] == it_ff.id);
   // one entry per cycle; finish on a hit or at the table end
   assign sdone    = hit || (sp_ff >= cnt_ff);
   assign full     = !found_ff && (cnt_ff >= MAXR);
   assign newidx   = cnt_ff[RW-1:0];
   assign last_idx = RW'(cnt_ff - CW'(1));
   assign is_new   = found_ff ? (seen_ff[fidx_ff] != gen_ff) : 1'b1;
   assign nrd      = ((len_ff < it_ff.max_len) ? len_ff : it_ff.max_len);
   assign wr_take  = it_ff.bvalid && (wpos_ff < cap);
   assign wr_pos   = wpos_ff + {6'd0, wr_take};
   assign wr_len   = (wr_pos < cap) ? wr_pos : cap;
   assign rpos_nx  = rpos_ff + 7'd1;
   assign rd_addr  = cmd.exec ? '0 : (cmd.stream ? rpos_nx[AW-1:0] : rpos_ff[AW-1:0]);

   assign stat.search_done = sdone;
   assign stat.stream_last = (rpos_nx >= rlen_ff);
   assign stat.has_stream  = strm_now;
   assign stat.has_result  = res_now;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         it_ff    <= item;
         sp_ff    <= '0;
         found_ff <= 1'b0;
      end else if (cmd.search && !found_ff) begin
         if (hit) begin
            found_ff <= 1'b1;
            fidx_ff  <= sidx;
         end else if (!sdone) begin
            sp_ff <= sp_ff + CW'(1);
         end
      end
   end

   // result decision, valid during the execute cycle
   always_comb begin
      strm_now  = 1'b0;
      res_now   = 1'b1;
      st_exec   = ST_OK;
      olen_exec = '0;
      case (it_ff.req)
         REQ_WRITE: begin
            res_now = it_ff.last;
            if (it_ff.last) olen_exec = wr_len;
         end
         REQ_READ, REQ_POLL: begin
            if (it_ff.req == REQ_POLL && gen_ff == 32'd0) st_exec = ST_NONEW;
            else if (full) st_exec = ST_FULL;
            else if (gen_ff == 32'd0 || !is_new) st_exec = ST_NONEW;
            else if (it_ff.req == REQ_READ) begin
               olen_exec = nrd;
               strm_now  = (nrd != 7'd0);
            end
         end
         REQ_CLOSE, REQ_RESET: ;
         default: res_now = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && it_ff.req == REQ_WRITE && wr_take)
         store[wpos_ff[AW-1:0]] <= it_ff.data;
      rd_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         len_ff  <= '0;
         wpos_ff <= '0;
         gen_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         if (cfg_we) cap_ff <= cfg_data;
         if (cmd.stream) rpos_ff <= rpos_nx;
         if (cmd.exec) begin
            st_ff   <= st_exec;
            olen_ff <= olen_exec;
            rlen_ff <= nrd;
            rpos_ff <= '0;
            case (it_ff.req)
               REQ_WRITE: begin
                  if (it_ff.last) begin
                     len_ff  <= wr_len;
                     wpos_ff <= '0;
                     gen_ff  <= gen_next;
                  end else begin
                     wpos_ff <= wr_pos;
                  end
               end
               REQ_READ, REQ_POLL: begin
                  if (!(it_ff.req == REQ_POLL && gen_ff == 32'd0) && !full) begin
                     if (!found_ff) begin
                        ids_ff[newidx]  <= it_ff.id;
                        seen_ff[newidx] <= (it_ff.req == REQ_READ && gen_ff != 32'd0)
                                           ? gen_ff : 32'd0;
                        cnt_ff <= cnt_ff + CW'(1);
                     end else if (it_ff.req == REQ_READ && gen_ff != 32'd0) begin
                        seen_ff[fidx_ff] <= gen_ff;
                     end
                  end
               end
               REQ_CLOSE: begin
                  if (found_ff) begin
                     ids_ff[fidx_ff]  <= ids_ff[last_idx];
                     seen_ff[fidx_ff] <= seen_ff[last_idx];
                     cnt_ff <= cnt_ff - CW'(1);
                  end
               end
               REQ_RESET: begin
                  len_ff  <= '0;
                  wpos_ff <= '0;
                  gen_ff  <= '0;
                  cnt_ff  <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pres_ff <= 1'b0;
      else if (cmd.exec) pres_ff <= strm_now;
   end

   assign o_status  = st_ff;
   assign o_length  = olen_ff;
   assign o_present = pres_ff;
   assign o_data    = pres_ff ? rd_ff : 8'd0;
   assign o_last    = pres_ff ? stat.stream_last : 1'b1;

   logic unused;
   assign unused = out_ready;
endmodule
`default_nettype wire
